### src/websocket_frame_header_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// websocket frame header parser unit - assertion macros
// shared concurrent assertion forms used by the parser rtl
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WSFHP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfhp same-cycle check failed");

// next-cycle implication, disabled during reset
`define WSFHP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfhp next-cycle check failed");

`endif

### src/wsfhp_pkg.sv
// ---------------------------------------------------------------------------
// wsfhp_pkg
// types and codes shared by the websocket frame header parser files
// ---------------------------------------------------------------------------
package wsfhp_pkg;

  localparam int TDATA_W = 120;
  localparam int TUSER_W = 2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_RSV_BIT   = 3'd0;
  localparam logic [2:0] ERR_RSV_OP    = 3'd1;
  localparam logic [2:0] ERR_LEN_TOP   = 3'd2;
  localparam logic [2:0] ERR_CTRL_LONG = 3'd3;
  localparam logic [2:0] ERR_CTRL_FRAG = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        mask;
    logic [31:0] key;
    logic [62:0] plen;
    logic [3:0]  hlen;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  err;
  } result_t;

endpackage

### src/wsfhp_parse.sv
// ---------------------------------------------------------------------------
// wsfhp_parse
// frame state and single-pass decode of one stream byte into a result
// ---------------------------------------------------------------------------
module wsfhp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          byte_in,
  output logic                res_valid,
  output wsfhp_pkg::result_t  res
);
  import wsfhp_pkg::*;

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  ext_r, ext_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [62:0] rem_r, rem_nxt;
  logic [3:0]  hc_r, hc_nxt;

  always_comb begin
    logic        known;
    logic        hdr;
    logic [63:0] k_len;
    logic [31:0] h_key;
    logic        h_mask;

    phase_nxt = phase_r;
    first_nxt = first_r;
    mask_nxt  = mask_r;
    ext_nxt   = ext_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    hc_nxt    = hc_r;
    res_valid = 1'b0;
    res       = '0;
    known     = 1'b0;
    hdr       = 1'b0;
    k_len     = len_r;
    h_key     = key_r;
    h_mask    = mask_r;

    case (phase_r)
      PH_FIRST: begin
        first_nxt = byte_in;
        hc_nxt    = 4'd1;
        mask_nxt  = 1'b0;
        ext_nxt   = 4'd0;
        len_nxt   = '0;
        key_nxt   = '0;
        rem_nxt   = '0;
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        hc_nxt   = 4'd2;
        mask_nxt = byte_in[7];
        h_mask   = byte_in[7];
        if (first_r[6:4] != 3'd0) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_RSV_BIT;
          phase_nxt = PH_HALT;
        end else if ((first_r[3:0] > 4'h2 && first_r[3:0] < 4'h8) ||
                     first_r[3:0] > 4'hA) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_RSV_OP;
          phase_nxt = PH_HALT;
        end else if (byte_in[6:0] < 7'd126) begin
          len_nxt = {57'd0, byte_in[6:0]};
          k_len   = {57'd0, byte_in[6:0]};
          known   = 1'b1;
        end else begin
          len_nxt   = '0;
          ext_nxt   = (byte_in[6:0] == 7'd126) ? 4'd2 : 4'd8;
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        len_nxt = {len_r[55:0], byte_in};
        k_len   = {len_r[55:0], byte_in};
        hc_nxt  = hc_r + 4'd1;
        ext_nxt = (ext_r != 4'd0) ? ext_r - 4'd1 : ext_r;
        if (ext_nxt == 4'd0) begin
          if (k_len[63]) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_LEN_TOP;
            phase_nxt = PH_HALT;
          end else begin
            known = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], byte_in};
        h_key   = {key_r[23:0], byte_in};
        hc_nxt  = hc_r + 4'd1;
        ext_nxt = (ext_r != 4'd0) ? ext_r - 4'd1 : ext_r;
        if (ext_nxt == 4'd0) begin
          hdr = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.data  = byte_in;
        rem_nxt   = (rem_r != '0) ? rem_r - 63'd1 : rem_r;
        if (rem_nxt == '0) begin
          res.last  = 1'b1;
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        // halted after an error: bytes are swallowed until reset
      end
    endcase

    // length now known: control frame checks, then key or header
    if (known) begin
      if (first_r[3] && (k_len[63:7] != '0 || k_len[6:0] > 7'd125)) begin
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
        res.err   = ERR_CTRL_LONG;
        phase_nxt = PH_HALT;
      end else if (first_r[3] && !first_r[7]) begin
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
        res.err   = ERR_CTRL_FRAG;
        phase_nxt = PH_HALT;
      end else if (h_mask) begin
        key_nxt   = '0;
        ext_nxt   = 4'd4;
        phase_nxt = PH_KEY;
      end else begin
        hdr = 1'b1;
      end
    end

    if (hdr) begin
      res_valid  = 1'b1;
      res.kind   = KIND_HEADER;
      res.fin    = first_r[7];
      res.opcode = first_r[3:0];
      res.mask   = h_mask;
      res.key    = h_mask ? h_key : 32'd0;
      res.plen   = k_len[62:0];
      res.hlen   = hc_nxt;
      res.last   = (k_len[62:0] == '0);
      if (k_len[62:0] == '0) begin
        phase_nxt = PH_FIRST;
      end else begin
        rem_nxt   = k_len[62:0];
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
    end else if (step_en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      first_r <= first_nxt;
      mask_r  <= mask_nxt;
      ext_r   <= ext_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      rem_r   <= rem_nxt;
      hc_r    <= hc_nxt;
    end
  end

endmodule

### src/websocket_frame_header_parser_unit.sv
// ---------------------------------------------------------------------------
// websocket_frame_header_parser_unit
// receive-side websocket frame header parser with raw payload pass-through
// ---------------------------------------------------------------------------
// Takes one stream byte per transaction and sustains one byte per clock
// cycle while the output is not stalled. Each byte sits in an input
// register while the decode stage updates the frame state and forms at most
// one result, which lands in the output register: a result is presented
// from the output register after its byte has passed the input register.
// Header bytes that do not complete a header give no result. A protocol error
// gives one error result, after which all bytes are swallowed until reset.
// Back-pressure on the output stalls the decode stage only when it has a
// result to deliver.
`include "websocket_frame_header_parser_unit_defines.svh"

module websocket_frame_header_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // stream_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fin_flag, frame_opcode, mask_present, masking_key, payload_bytes,
  // header_bytes, payload_data, error_code, zero pad
  output logic [wsfhp_pkg::TDATA_W-1:0] out_tdata,
  output logic [wsfhp_pkg::TUSER_W-1:0] out_tuser,  // result_kind
  output logic                          out_tlast   // frame_last
);
  import wsfhp_pkg::*;

  logic    s1_valid_r;
  logic    [7:0] s1_byte_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    res_valid;
  logic    out_free;
  logic    step_en;

  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && (!res_valid || out_free);
  assign in_tready = !s1_valid_r || step_en;

  wsfhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .byte_in   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (step_en && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {4'd0, out_res_r.err, out_res_r.data, out_res_r.hlen,
                       out_res_r.plen, out_res_r.key, out_res_r.mask,
                       out_res_r.opcode, out_res_r.fin};

  // a pending result must never be overwritten while the output is stalled
  `WSFHP_ASSERT_NOW(a_no_overwrite, clk, rst_n, s1_valid_r && res_valid && !out_free, !step_en)
  `WSFHP_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_tvalid && in_tready, s1_valid_r)
  `WSFHP_ASSERT_NOW(a_kind_legal, clk, rst_n, out_valid_r, out_res_r.kind != 2'd3)
  `WSFHP_ASSERT_NOW(a_err_not_last, clk, rst_n, out_valid_r && out_res_r.kind == KIND_ERROR, !out_res_r.last)
  `WSFHP_ASSERT_NOW(a_hdr_last, clk, rst_n, out_valid_r && out_res_r.kind == KIND_HEADER, out_res_r.last == (out_res_r.plen == '0))

endmodule
